// ===== src/dpalu_pkg.sv =====
package dpalu_pkg;

  // Data-processing opcodes, bits 24-21 of the instruction word
  typedef enum logic [3:0] {
    OP_AND = 4'b0000,
    OP_EOR = 4'b0001,
    OP_SUB = 4'b0010,
    OP_RSB = 4'b0011,
    OP_ADD = 4'b0100,
    OP_ADC = 4'b0101,
    OP_SBC = 4'b0110,
    OP_RSC = 4'b0111,
    OP_TST = 4'b1000,
    OP_TEQ = 4'b1001,
    OP_CMP = 4'b1010,
    OP_CMN = 4'b1011,
    OP_ORR = 4'b1100,
    OP_MOV = 4'b1101,
    OP_BIC = 4'b1110,
    OP_MVN = 4'b1111
  } opcode_e;

  // Register-form shift kinds, bits 6-5
  typedef enum logic [1:0] {
    SH_LSL = 2'b00,
    SH_LSR = 2'b01,
    SH_ASR = 2'b10,
    SH_ROR = 2'b11
  } shift_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RegW   = 4;
  localparam int unsigned FlagsW = 4;

  localparam logic [RegW-1:0] PcReg = 4'd15;

  // Instruction word bit positions
  localparam int unsigned ImmFormBit = 25;
  localparam int unsigned SBit       = 20;
  localparam int unsigned RegShBit   = 4;

  typedef struct packed {
    logic [DataW-1:0]  instruction;
    logic [DataW-1:0]  rn_value;
    logic [DataW-1:0]  rm_value;
    logic [DataW-1:0]  rs_value;
    logic              has_spsr;
    logic [FlagsW-1:0] spsr_flags;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0]  result;
    logic              write_result;
    logic [RegW-1:0]   dest_reg;
    logic [FlagsW-1:0] flags_out;
    logic              restore_status;
  } out_t;

endpackage

// ===== src/data_processing_alu_with_shifter.sv =====
// Channel | Direction | Handshake                | Word
// --------+-----------+--------------------------+-----------------------------
// in      | input     | in_valid_i / in_stall_o   | dpalu_pkg::in_t  (in_data_i)
// out     | output    | out_valid_o / out_stall_i | dpalu_pkg::out_t (out_data_o)
//
// One word per cycle sustained while the output is not stalled; an accepted word
// waits in the input register and then moves on to the result register.
// Shifter, ALU and flags sit between the two registers; NZCV updates as a word
// enters the result register, so the next word always sees the new flags.
// Reset clears both valid bits and NZCV. An output stall with the result register
// full holds it and, with the input register full, raises in_stall_o at once.
module data_processing_alu_with_shifter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dpalu_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dpalu_pkg::out_t out_data_o
);

  // ---------------------------------------------------------------------------
  // Stage registers and handshake
  // ---------------------------------------------------------------------------
  logic                            s1_valid_q;
  dpalu_pkg::in_t                  s1_data_q;
  logic                            out_valid_q;
  dpalu_pkg::out_t                 out_data_q;
  logic [dpalu_pkg::FlagsW-1:0]    nzcv_q;
  logic [dpalu_pkg::FlagsW-1:0]    nzcv_d;
  dpalu_pkg::out_t                 out_data_d;

  logic s1_fire;  // word moves from the input register to the result register
  logic in_fire;  // word accepted on the input channel

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Instruction decode
  // ---------------------------------------------------------------------------
  logic [dpalu_pkg::DataW-1:0] ins;
  dpalu_pkg::opcode_e          opcode;
  dpalu_pkg::shift_e           sh_kind;
  logic                        s_bit;
  logic [dpalu_pkg::RegW-1:0]  rd;

  assign ins     = s1_data_q.instruction;
  assign opcode  = dpalu_pkg::opcode_e'(ins[24:21]);
  assign sh_kind = dpalu_pkg::shift_e'(ins[6:5]);
  assign s_bit   = ins[dpalu_pkg::SBit];
  assign rd      = ins[15:12];

  // ---------------------------------------------------------------------------
  // Shifter operand
  // ---------------------------------------------------------------------------
  logic [63:0] imm_rot_w;   // doubled 8-bit immediate, rotated right
  logic [63:0] rm_rot_w;    // doubled Rm, rotated right
  logic [7:0]  sh_amt;      // shift amount: immediate field or low byte of Rs
  logic        sh_large;    // amount of 32 or more
  logic [31:0] rm;
  logic [31:0] rm_shifted;
  logic [31:0] op2;

  assign rm        = s1_data_q.rm_value;
  assign imm_rot_w = {24'b0, ins[7:0], 24'b0, ins[7:0]} >> {ins[11:8], 1'b0};
  assign sh_amt    = ins[dpalu_pkg::RegShBit] ? s1_data_q.rs_value[7:0]
                                              : {3'b000, ins[11:7]};
  assign sh_large  = |sh_amt[7:5];
  assign rm_rot_w  = {rm, rm} >> sh_amt[4:0];

  always_comb begin
    rm_shifted = rm;
    if (sh_amt != 8'd0) begin
      case (sh_kind)
        dpalu_pkg::SH_LSL: rm_shifted = sh_large ? 32'd0 : (rm << sh_amt[4:0]);
        dpalu_pkg::SH_LSR: rm_shifted = sh_large ? 32'd0 : (rm >> sh_amt[4:0]);
        dpalu_pkg::SH_ASR: begin
          // fill with the sign bit once the amount reaches the word width
          rm_shifted = sh_large ? {32{rm[31]}}
                                : $unsigned($signed(rm) >>> sh_amt[4:0]);
        end
        dpalu_pkg::SH_ROR: rm_shifted = rm_rot_w[31:0];
        default:           rm_shifted = rm;
      endcase
    end
  end

  assign op2 = ins[dpalu_pkg::ImmFormBit] ? imm_rot_w[31:0] : rm_shifted;

  // ---------------------------------------------------------------------------
  // ALU: one shared 33-bit adder, operands steered by opcode
  // ---------------------------------------------------------------------------
  logic [31:0] rn;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] sum_w;
  logic        add_v;
  logic        c_in;
  logic [31:0] res;
  logic        arith;     // C and V come from the adder
  logic        test_op;   // TST, TEQ, CMP, CMN: no write, flags always set

  assign rn   = s1_data_q.rn_value;
  assign c_in = nzcv_q[1];

  always_comb begin
    add_a   = rn;
    add_b   = op2;
    add_cin = 1'b0;
    case (opcode)
      dpalu_pkg::OP_SUB, dpalu_pkg::OP_CMP: begin
        add_b   = ~op2;
        add_cin = 1'b1;
      end
      dpalu_pkg::OP_RSB: begin
        add_a   = op2;
        add_b   = ~rn;
        add_cin = 1'b1;
      end
      dpalu_pkg::OP_ADC: add_cin = c_in;
      dpalu_pkg::OP_SBC: begin
        add_b   = ~op2;
        add_cin = c_in;
      end
      dpalu_pkg::OP_RSC: begin
        add_a   = op2;
        add_b   = ~rn;
        add_cin = c_in;
      end
      default: begin
        add_a   = rn;
        add_b   = op2;
        add_cin = 1'b0;
      end
    endcase
  end

  assign sum_w = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_v = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum_w[31]);

  always_comb begin
    res     = sum_w[31:0];
    arith   = 1'b1;
    test_op = 1'b0;
    case (opcode)
      dpalu_pkg::OP_AND: begin res = rn & op2;  arith = 1'b0; end
      dpalu_pkg::OP_EOR: begin res = rn ^ op2;  arith = 1'b0; end
      dpalu_pkg::OP_SUB,
      dpalu_pkg::OP_RSB,
      dpalu_pkg::OP_ADD,
      dpalu_pkg::OP_ADC,
      dpalu_pkg::OP_SBC,
      dpalu_pkg::OP_RSC: res = sum_w[31:0];
      dpalu_pkg::OP_TST: begin
        res     = rn & op2;
        arith   = 1'b0;
        test_op = 1'b1;
      end
      dpalu_pkg::OP_TEQ: begin
        res     = rn ^ op2;
        arith   = 1'b0;
        test_op = 1'b1;
      end
      dpalu_pkg::OP_CMP,
      dpalu_pkg::OP_CMN: begin
        res     = sum_w[31:0];
        test_op = 1'b1;
      end
      dpalu_pkg::OP_ORR: begin res = rn | op2;  arith = 1'b0; end
      dpalu_pkg::OP_MOV: begin res = op2;       arith = 1'b0; end
      dpalu_pkg::OP_BIC: begin res = rn & ~op2; arith = 1'b0; end
      dpalu_pkg::OP_MVN: begin res = ~op2;      arith = 1'b0; end
      default: begin
        res   = sum_w[31:0];
        arith = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flags and result word
  // ---------------------------------------------------------------------------
  logic upd;       // flags are touched by this word
  logic to_pc;     // written result goes to the PC
  logic restore;
  logic new_c;
  logic new_v;

  assign upd     = s_bit || test_op;
  assign to_pc   = !test_op && (rd == dpalu_pkg::PcReg);
  assign restore = upd && to_pc && s1_data_q.has_spsr;
  // logical ops keep C and V
  assign new_c   = arith ? sum_w[32] : nzcv_q[1];
  assign new_v   = arith ? add_v     : nzcv_q[0];

  always_comb begin
    nzcv_d = nzcv_q;
    if (upd) begin
      if (to_pc) begin
        // load from SPSR when one exists, otherwise hold the flags
        if (s1_data_q.has_spsr) begin
          nzcv_d = s1_data_q.spsr_flags;
        end
      end else begin
        nzcv_d = {res[31], (res == 32'd0), new_c, new_v};
      end
    end
  end

  always_comb begin
    out_data_d.result         = res;
    out_data_d.write_result   = !test_op;
    out_data_d.dest_reg       = rd;
    out_data_d.flags_out      = nzcv_d;
    out_data_d.restore_status = restore;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      nzcv_q      <= '0;
    end else begin
      // input register refills whenever it empties or advances
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      // result register: load on advance, drop when taken
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        nzcv_q      <= nzcv_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The flag register always matches the flags of the word held for output.
  a_flags_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.flags_out == nzcv_q))
    else $error("NZCV register differs from flags of held result");

  // Flags change only when a word moves into the result register.
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(nzcv_q))
    else $error("NZCV changed without an advancing word");

  // A restore is only ever requested for a written result to the PC.
  a_restore_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.restore_status) |->
      (out_data_q.write_result && (out_data_q.dest_reg == dpalu_pkg::PcReg)))
    else $error("status restore without a PC write");

endmodule
